// ===== rtl/core/bmf_pkg.sv =====
// Shared constants and types for the box mean filter.
// Holds the item word passed from the front end through the queue to the back end.
// No dependencies.
package bmf_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_MASK     = 16;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int QDEPTH       = 4;

  localparam int PIX_W   = 8;
  localparam int DIM_W   = 11;
  localparam int MASK_W  = 5;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int SLOT_W  = $clog2(MAX_MASK);
  localparam int CSUM_W  = 12;
  localparam int WSUM_W  = 16;
  localparam int CIDX_W  = 2;

  typedef enum logic [CIDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MASK   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [SLOT_W-1:0] rd_slot;
    logic [SLOT_W-1:0] wr_slot;
    logic [COL_W-1:0]  col;
    logic              row_zero;
    logic              row_ge_mask;
    logic              col_zero;
    logic              col_ge_mask;
    logic              emit;
    logic [SLOT_W-1:0] mask_idx;
    logic [COL_W-1:0]  center_row;
    logic [COL_W-1:0]  center_col;
  } bmf_item_t;

endpackage

// ===== rtl/core/bmf_front.sv =====
// Front end of the box mean filter: configuration registers, raster position
// tracking and classification of each pixel word into a queue item.
// Depends on bmf_pkg.
module bmf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bmf_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [bmf_pkg::DIM_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bmf_pkg::PIX_W-1:0]   pixel_i,
  input  logic                        frame_start_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output bmf_pkg::bmf_item_t          item_o
);
  import bmf_pkg::*;

  logic [DIM_W-1:0]  width_q, height_q;
  logic [MASK_W-1:0] mask_q;
  logic [COL_W-1:0]  r_q, c_q;

  logic [DIM_W-1:0]  width_sat, height_sat;
  logic [MASK_W-1:0] mask_sat;
  logic              cfg_hit;

  logic [COL_W-1:0]  r_sel, c_sel, r_nxt, c_nxt;
  logic [DIM_W-1:0]  r_ext, c_ext, m_ext, c_inc, r_inc;
  logic              accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign accept      = in_valid_i && !q_full_i;
  assign push_o      = accept;

  always_comb begin
    if (cfg_data_i == '0) begin
      width_sat  = DIM_W'(1);
      height_sat = DIM_W'(1);
    end else begin
      width_sat  = (cfg_data_i > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : cfg_data_i;
      height_sat = (cfg_data_i > DIM_W'(HEIGHT_LIMIT)) ? DIM_W'(HEIGHT_LIMIT) : cfg_data_i;
    end
    if (cfg_data_i[MASK_W-1:0] == '0) begin
      mask_sat = MASK_W'(1);
    end else if (cfg_data_i[MASK_W-1:0] > MASK_W'(MAX_MASK)) begin
      mask_sat = MASK_W'(MAX_MASK);
    end else begin
      mask_sat = cfg_data_i[MASK_W-1:0];
    end
    case (cfg_reg_e'(cfg_index_i))
      CFG_WIDTH, CFG_HEIGHT, CFG_MASK: cfg_hit = cfg_valid_i;
      default:                         cfg_hit = 1'b0;
    endcase
  end

  always_comb begin
    r_sel = frame_start_i ? '0 : r_q;
    c_sel = frame_start_i ? '0 : c_q;
    if (DIM_W'(r_sel) >= height_q || DIM_W'(c_sel) >= width_q) begin
      r_sel = '0;
      c_sel = '0;
    end
    r_ext = DIM_W'(r_sel);
    c_ext = DIM_W'(c_sel);
    m_ext = DIM_W'(mask_q);

    item_o.pixel       = pixel_i;
    item_o.rd_slot     = r_sel[SLOT_W-1:0] - mask_q[SLOT_W-1:0];
    item_o.wr_slot     = r_sel[SLOT_W-1:0];
    item_o.col         = c_sel;
    item_o.row_zero    = (r_sel == '0);
    item_o.row_ge_mask = (r_ext >= m_ext);
    item_o.col_zero    = (c_sel == '0);
    item_o.col_ge_mask = (c_ext >= m_ext);
    item_o.emit        = ((r_ext + DIM_W'(1)) >= m_ext) && ((c_ext + DIM_W'(1)) >= m_ext);
    item_o.mask_idx    = SLOT_W'(mask_q - MASK_W'(1));
    item_o.center_row  = COL_W'(r_ext + DIM_W'(1) - m_ext + (m_ext >> 1));
    item_o.center_col  = COL_W'(c_ext + DIM_W'(1) - m_ext + (m_ext >> 1));

    c_inc = c_ext + DIM_W'(1);
    r_inc = r_ext + DIM_W'(1);
    if (c_inc >= width_q) begin
      c_nxt = '0;
      r_nxt = (r_inc >= height_q) ? '0 : COL_W'(r_inc);
    end else begin
      c_nxt = COL_W'(c_inc);
      r_nxt = r_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(640);
      height_q <= DIM_W'(480);
      mask_q   <= MASK_W'(3);
      r_q      <= '0;
      c_q      <= '0;
    end else if (cfg_hit) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= width_sat;
        CFG_HEIGHT: height_q <= height_sat;
        CFG_MASK:   mask_q   <= mask_sat;
        default:    ;
      endcase
      r_q <= '0;
      c_q <= '0;
    end else if (accept) begin
      r_q <= r_nxt;
      c_q <= c_nxt;
    end
  end

endmodule

// ===== rtl/core/bmf_queue.sv =====
// Short queue of classified items between the front and back ends.
// Depends on bmf_pkg.
module bmf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bmf_pkg::bmf_item_t item_i,
  output logic               full_o,
  output logic               valid_o,
  output bmf_pkg::bmf_item_t item_o,
  input  logic               pop_i
);
  import bmf_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  bmf_item_t        entry_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QDEPTH))
    else $error("queue count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("queue count did not advance on push");

endmodule

// ===== rtl/core/bmf_back.sv =====
// Back end of the box mean filter: row store and column sum memories with
// one-level bypass, window sum, reciprocal multiply and the output register.
// Depends on bmf_pkg.
module bmf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  bmf_pkg::bmf_item_t         q_item_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bmf_pkg::PIX_W-1:0]  mean_value_o,
  output logic [bmf_pkg::COL_W-1:0]  center_row_o,
  output logic [bmf_pkg::COL_W-1:0]  center_col_o
);
  import bmf_pkg::*;

  localparam int ROW_DEPTH   = MAX_MASK * MAX_WIDTH;
  localparam int RADDR_W     = SLOT_W + COL_W;
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 24;
  localparam int PROD_W      = WSUM_W + RECIP_W;

  // ceil(2^24 / m^2) for m = 1 .. 16; exact floor for any 16-bit window sum
  localparam logic [RECIP_W-1:0] RECIP_TABLE [MAX_MASK] = '{
    25'd16777216, 25'd4194304, 25'd1864136, 25'd1048576,
    25'd671089,   25'd466034,  25'd342393,  25'd262144,
    25'd207127,   25'd167773,  25'd138655,  25'd116509,
    25'd99274,    25'd85599,   25'd74566,   25'd65536
  };

  typedef struct packed {
    logic [CSUM_W-1:0] cs;
    logic              col_zero;
    logic              col_ge_mask;
    logic              emit;
    logic [SLOT_W-1:0] mask_idx;
    logic [COL_W-1:0]  center_row;
    logic [COL_W-1:0]  center_col;
  } sum_stage_t;

  typedef struct packed {
    logic [WSUM_W-1:0] ws;
    logic              emit;
    logic [SLOT_W-1:0] mask_idx;
    logic [COL_W-1:0]  center_row;
    logic [COL_W-1:0]  center_col;
  } div_stage_t;

  logic [PIX_W-1:0]  row_mem  [ROW_DEPTH];
  logic [CSUM_W-1:0] csum_mem [MAX_WIDTH];

  logic              adv, pop;
  logic [RADDR_W-1:0] rd_addr, wr_addr;

  bmf_item_t         p1_q;
  logic              p1_valid_q;
  logic [PIX_W-1:0]  rs_rd_q, rs_fwd_data_q;
  logic [CSUM_W-1:0] cs_rd_q, cs_fwd_data_q;
  logic              rs_fwd_q, cs_fwd_q;
  logic [PIX_W-1:0]  rs_old;
  logic [CSUM_W-1:0] cs_old, cs_p1;

  sum_stage_t        p2_q;
  logic              p2_valid_q;
  logic [CSUM_W-1:0] hist_q [MAX_MASK];
  logic [WSUM_W-1:0] ws_q, ws_d;

  div_stage_t        p3_q;
  logic              p3_valid_q;
  logic [PROD_W-1:0] prod;

  logic              out_valid_q;
  logic [PIX_W-1:0]  mean_q;
  logic [COL_W-1:0]  crow_q, ccol_q;

  assign adv     = !out_valid_q || out_ready_i;
  assign pop     = adv && q_valid_i;
  assign pop_o   = pop;
  assign rd_addr = {q_item_i.rd_slot, q_item_i.col};
  assign wr_addr = {p1_q.wr_slot, p1_q.col};

  always_comb begin
    rs_old = rs_fwd_q ? rs_fwd_data_q : rs_rd_q;
    cs_old = cs_fwd_q ? cs_fwd_data_q : cs_rd_q;
    cs_p1  = (p1_q.row_zero ? '0 : cs_old)
           - (p1_q.row_ge_mask ? CSUM_W'(rs_old) : '0)
           + CSUM_W'(p1_q.pixel);
  end

  always_comb begin
    ws_d = (p2_q.col_zero ? '0 : ws_q)
         + WSUM_W'(p2_q.cs)
         - (p2_q.col_ge_mask ? WSUM_W'(hist_q[p2_q.mask_idx]) : '0);
  end

  assign prod = PROD_W'(p3_q.ws) * PROD_W'(RECIP_TABLE[p3_q.mask_idx]);

  always_ff @(posedge clk_i) begin
    if (pop) begin
      rs_rd_q <= row_mem[rd_addr];
    end
    if (adv && p1_valid_q) begin
      row_mem[wr_addr] <= p1_q.pixel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cs_rd_q <= csum_mem[q_item_i.col];
    end
    if (adv && p1_valid_q) begin
      csum_mem[p1_q.col] <= cs_p1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q          <= q_item_i;
      rs_fwd_data_q <= p1_q.pixel;
      cs_fwd_data_q <= cs_p1;

      p2_q.cs          <= cs_p1;
      p2_q.col_zero    <= p1_q.col_zero;
      p2_q.col_ge_mask <= p1_q.col_ge_mask;
      p2_q.emit        <= p1_q.emit;
      p2_q.mask_idx    <= p1_q.mask_idx;
      p2_q.center_row  <= p1_q.center_row;
      p2_q.center_col  <= p1_q.center_col;

      if (p2_valid_q) begin
        hist_q[0] <= p2_q.cs;
        for (int i = 1; i < MAX_MASK; i++) begin
          hist_q[i] <= hist_q[i-1];
        end
      end

      p3_q.ws         <= ws_d;
      p3_q.emit       <= p2_q.emit;
      p3_q.mask_idx   <= p2_q.mask_idx;
      p3_q.center_row <= p2_q.center_row;
      p3_q.center_col <= p2_q.center_col;

      if (p3_valid_q && p3_q.emit) begin
        mean_q <= prod[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
        crow_q <= p3_q.center_row;
        ccol_q <= p3_q.center_col;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      p3_valid_q  <= 1'b0;
      rs_fwd_q    <= 1'b0;
      cs_fwd_q    <= 1'b0;
      ws_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        p1_valid_q <= q_valid_i;
        p2_valid_q <= p1_valid_q;
        p3_valid_q <= p2_valid_q;
        rs_fwd_q   <= pop && p1_valid_q && (rd_addr == wr_addr);
        cs_fwd_q   <= pop && p1_valid_q && (q_item_i.col == p1_q.col);
        if (p2_valid_q) begin
          ws_q <= ws_d;
        end
        out_valid_q <= p3_valid_q && p3_q.emit;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mean_value_o = mean_q;
  assign center_row_o = crow_q;
  assign center_col_o = ccol_q;

  a_rs_fwd_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rs_fwd_q |-> p1_valid_q)
    else $error("row store bypass without a live item");

  a_cs_fwd_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cs_fwd_q |-> p1_valid_q)
    else $error("column sum bypass without a live item");

  a_ws_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && p2_valid_q && p2_q.col_zero) |=> (ws_q == WSUM_W'($past(p2_q.cs))))
    else $error("window sum not restarted at row start");

endmodule

// ===== rtl/core/box_mean_filter_2d.sv =====
// Top level of the streaming 2D box mean filter.
// Instantiates bmf_front, bmf_queue and bmf_back; depends on bmf_pkg.
//
// Pixels enter in raster order, one word per clock while the queue has
// room, and each full mask_size x mask_size window yields one word: the
// truncated mean and the window centre. The back end is a four-deep
// pipeline (memory read, column sum, window sum, reciprocal multiply)
// whose row store and column sum memories each take one read and one
// write per clock; a stalled output backs up through the four-word queue
// before the input stops. The memories need no clearing pass after reset.
// Register writes restart the image at row 0, column 0 and are to be
// issued only while no pixel is in flight.
module box_mean_filter_2d (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bmf_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [bmf_pkg::DIM_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bmf_pkg::PIX_W-1:0]   pixel_i,
  input  logic                        frame_start_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bmf_pkg::PIX_W-1:0]   mean_value_o,
  output logic [bmf_pkg::COL_W-1:0]   center_row_o,
  output logic [bmf_pkg::COL_W-1:0]   center_col_o
);
  import bmf_pkg::*;

  bmf_item_t push_item, head_item;
  logic      push, q_full, q_valid, pop;

  bmf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  bmf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (head_item),
    .pop_i   (pop)
  );

  bmf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mean_value_o (mean_value_o),
    .center_row_o (center_row_o),
    .center_col_o (center_col_o)
  );

endmodule
